### rtl/point_to_target_mover_core_macros.svh
// Assertion macros for the point-to-target mover RTL.
// Used by ptm_ctrl; expects clk_i and rst_ni in scope.
`ifndef POINT_TO_TARGET_MOVER_CORE_MACROS_SVH
`define POINT_TO_TARGET_MOVER_CORE_MACROS_SVH

// same-cycle implication
`define PTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptm_pkg.sv
// Shared types, codes and helpers for the point-to-target mover.
// No dependencies.
package ptm_pkg;

  localparam logic [2:0] CFG_SPEED  = 3'd0;
  localparam logic [2:0] CFG_X_MIN  = 3'd1;
  localparam logic [2:0] CFG_Y_MIN  = 3'd2;
  localparam logic [2:0] CFG_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  localparam logic [15:0] SPEED_RST  = 16'd960;
  localparam logic [15:0] X_MIN_RST  = 16'd256;
  localparam logic [15:0] Y_MIN_RST  = 16'd256;
  localparam logic [14:0] WIDTH_RST  = 15'd12288;
  localparam logic [14:0] HEIGHT_RST = 15'd9088;

  // squared snap radius: 4 px = 64 sub-pixels
  localparam logic [33:0] SNAP_SQ = 34'd4096;

  localparam int unsigned SQRT_STEPS = 17;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned LANES      = 4;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_POS    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_SET_GOAL,
    OP_SET_POS,
    OP_ZERO_VEL,
    OP_DIFF,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SNAP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_STEP_MUL,
    OP_STEP_LIM,
    OP_LANE_MUL,
    OP_DIV_STEP,
    OP_UPDATE
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SQ_X, S_SQ_Y, S_CHECK, S_SQRT,
    S_STEP, S_LIMIT, S_LMUL, S_DIV, S_UPDATE, S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] lane;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       arrived;
    logic       near;
  } dp_stat_t;

  // clamp to [lo, min(lo + size, 32767)]; upper edge checked first
  function automatic logic signed [15:0] clamp_box(logic signed [17:0] v,
                                                   logic signed [15:0] lo,
                                                   logic [14:0] size);
    logic signed [17:0] hi;
    logic signed [17:0] lo_x;
    logic signed [17:0] r;
    lo_x = 18'(lo);
    hi   = lo_x + $signed({3'b000, size});
    if (hi > 18'sd32767) hi = 18'sd32767;
    if (v > hi)        r = hi;
    else if (v < lo_x) r = lo_x;
    else               r = v;
    return r[15:0];
  endfunction

endpackage

### rtl/point_to_target_mover_core.sv
// Top level of the point-to-target mover: sequencer plus datapath.
// Depends on ptm_pkg, ptm_ctrl and ptm_dp.
//
// Usage:
//  - Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
//    always ready; index 0 speed, 1 box x min, 2 box y min, 3 width,
//    4 height. Write only while the block is idle.
//  - Input beat: mode_i 0 = tick (uses tick_time_i), 1 = set target
//    (box-clamped, clears arrived), 2 = set position, 3 = report only.
//  - Every input beat yields exactly one output beat with the state after it.
//  - Steps from accept to output valid: set target, set position, report
//    only and a tick with arrived set pass dispatch and the output load;
//    a tick that snaps adds the x and y squarings and the check; a moving
//    tick runs dispatch, squarings, check, 17 root digits, step multiply,
//    step limit, four lane multiplies, divider steps, update, output load.
//  - One beat at a time; the next is taken the cycle after the current
//    one is loaded into the output register.
//  - Receiver stall: the result holds on the output ports and the sequencer
//    waits in its done state; nothing is dropped.
//  - Reset: position, target and velocity zero, arrived set, config back
//    to its defaults, no output pending.
module point_to_target_mover_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic [15:0]        tick_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [16:0] vel_x_o,
  output logic signed [16:0] vel_y_o,
  output logic               arrived_o
);
  import ptm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config registers accept a beat every cycle
  assign cfg_ready_o = 1'b1;

  ptm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .tick_time_i (tick_time_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .arrived_o   (arrived_o)
  );

endmodule

### rtl/ptm_ctrl.sv
// Sequencer for the point-to-target mover: state machine, step counter,
// result-valid flag. Depends on ptm_pkg and the core macros header.
`include "point_to_target_mover_core_macros.svh"

module ptm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptm_pkg::dp_stat_t stat_i,
  output ptm_pkg::dp_cmd_t  cmd_o
);
  import ptm_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.op       = OP_IDLE;
    cmd_o.lane     = cnt_q[1:0];
    cmd_o.load_out = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        if (stat_i.mode == MODE_TARGET) begin
          cmd_o.op = OP_SET_GOAL;
        end else if (stat_i.mode == MODE_POS) begin
          cmd_o.op = OP_SET_POS;
        end else if (stat_i.mode == MODE_TICK) begin
          if (stat_i.arrived) begin
            cmd_o.op = OP_ZERO_VEL;
          end else begin
            cmd_o.op = OP_DIFF;
            state_d  = S_SQ_X;
          end
        end
      end
      S_SQ_X: begin
        cmd_o.op = OP_SQ_X;
        state_d  = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.near) begin
          cmd_o.op = OP_SNAP;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SQRT_INIT;
          cnt_d    = 5'(SQRT_STEPS - 1);
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.op = OP_STEP_MUL;
        state_d  = S_LIMIT;
      end
      S_LIMIT: begin
        cmd_o.op = OP_STEP_LIM;
        cnt_d    = 5'(LANES - 1);
        state_d  = S_LMUL;
      end
      S_LMUL: begin
        cmd_o.op = OP_LANE_MUL;
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          cnt_d   = 5'(DIV_STEPS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `PTM_ASSERT_NXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == S_DISPATCH,
                  "accepted beat did not reach dispatch")
  `PTM_ASSERT_NXT(a_sqrt_exit, state_q == S_SQRT && cnt_q == '0, state_q == S_STEP,
                  "root iteration count wrong")
  `PTM_ASSERT_IMP(a_no_overwrite, cmd_o.load_out, !out_valid_q || out_ready_i,
                  "pending result overwritten")
  `PTM_ASSERT_NXT(a_hold_done, state_q == S_DONE && out_valid_q && !out_ready_i,
                  state_q == S_DONE, "left done while result stalled")

endmodule

### rtl/ptm_dp.sv
// Datapath of the point-to-target mover: config and state registers,
// shared multiplier, digit-by-digit root, four divider lanes, output regs.
// Depends on ptm_pkg.
module ptm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptm_pkg::dp_cmd_t   cmd_i,
  output ptm_pkg::dp_stat_t  stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic [15:0]        tick_time_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [16:0] vel_x_o,
  output logic signed [16:0] vel_y_o,
  output logic               arrived_o
);
  import ptm_pkg::*;

  logic [15:0]        speed_q;
  logic signed [15:0] x_min_q, y_min_q;
  logic [14:0]        width_q, height_q;

  logic signed [15:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
  logic signed [17:0] vel_x_q, vel_y_q;
  logic               arrived_q;

  logic [1:0]         mode_q;
  logic signed [15:0] cin_x_q, cin_y_q;
  logic [15:0]        dt_q;

  logic [15:0] dx_mag_q, dy_mag_q;
  logic        sx_q, sy_q;
  logic [33:0] d2_q;
  logic [18:0] sq_rem_q;
  logic [16:0] dist_q;
  logic [15:0] step_q;
  logic [16:0] rem_q [LANES];
  logic [15:0] quo_q [LANES];

  logic signed [15:0] pos_x_q, pos_y_q;
  logic signed [16:0] vel_x_oq, vel_y_oq;
  logic               arr_oq;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic signed [16:0] dx, dy;
  logic [16:0] dx_abs, dy_abs;
  logic [20:0] sq_r2, sq_t, sq_diff;
  logic signed [17:0] sum_x, sum_y, mv_x, mv_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RST;
      x_min_q  <= X_MIN_RST;
      y_min_q  <= Y_MIN_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPEED:  speed_q  <= cfg_data_i;
        CFG_X_MIN:  x_min_q  <= cfg_data_i;
        CFG_Y_MIN:  y_min_q  <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i[14:0];
        CFG_HEIGHT: height_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // shared 16x16 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ_X:     begin mul_a = dx_mag_q; mul_b = dx_mag_q; end
      OP_SQ_Y:     begin mul_a = dy_mag_q; mul_b = dy_mag_q; end
      OP_STEP_MUL: begin mul_a = speed_q;  mul_b = dt_q;     end
      OP_LANE_MUL: begin
        mul_a = cmd_i.lane[0] ? dy_mag_q : dx_mag_q;
        mul_b = cmd_i.lane[1] ? speed_q  : step_q;
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  assign dx     = 17'(goal_x_q) - 17'(cur_x_q);
  assign dy     = 17'(goal_y_q) - 17'(cur_y_q);
  assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);

  // one root digit per cycle
  assign sq_r2   = {sq_rem_q, d2_q[33:32]};
  assign sq_t    = {2'b00, dist_q, 2'b01};
  assign sq_diff = sq_r2 - sq_t;

  assign mv_x  = sx_q ? -18'($signed({2'b00, quo_q[0]})) : 18'($signed({2'b00, quo_q[0]}));
  assign mv_y  = sy_q ? -18'($signed({2'b00, quo_q[1]})) : 18'($signed({2'b00, quo_q[1]}));
  assign sum_x = 18'(cur_x_q) + mv_x;
  assign sum_y = 18'(cur_y_q) + mv_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      arrived_q <= 1'b1;
      mode_q    <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_CAPTURE: mode_q <= mode_i;
        OP_SET_GOAL: begin
          goal_x_q  <= clamp_box(18'(cin_x_q), x_min_q, width_q);
          goal_y_q  <= clamp_box(18'(cin_y_q), y_min_q, height_q);
          arrived_q <= 1'b0;
        end
        OP_SET_POS: begin
          cur_x_q <= cin_x_q;
          cur_y_q <= cin_y_q;
        end
        OP_ZERO_VEL: begin
          vel_x_q <= '0;
          vel_y_q <= '0;
        end
        OP_SNAP: begin
          cur_x_q   <= goal_x_q;
          cur_y_q   <= goal_y_q;
          vel_x_q   <= '0;
          vel_y_q   <= '0;
          arrived_q <= 1'b1;
        end
        OP_UPDATE: begin
          cur_x_q <= clamp_box(sum_x, x_min_q, width_q);
          cur_y_q <= clamp_box(sum_y, y_min_q, height_q);
          vel_x_q <= sx_q ? -18'($signed({2'b00, quo_q[2]})) : 18'($signed({2'b00, quo_q[2]}));
          vel_y_q <= sy_q ? -18'($signed({2'b00, quo_q[3]})) : 18'($signed({2'b00, quo_q[3]}));
        end
        default: ;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        cin_x_q <= coord_x_i;
        cin_y_q <= coord_y_i;
        dt_q    <= tick_time_i;
      end
      OP_DIFF: begin
        dx_mag_q <= dx_abs[15:0];
        dy_mag_q <= dy_abs[15:0];
        sx_q     <= dx[16];
        sy_q     <= dy[16];
      end
      OP_SQ_X: d2_q <= 34'(prod);
      OP_SQ_Y: d2_q <= d2_q + 34'(prod);
      OP_SQRT_INIT: begin
        sq_rem_q <= '0;
        dist_q   <= '0;
      end
      OP_SQRT_STEP: begin
        d2_q <= {d2_q[31:0], 2'b00};
        if (!sq_diff[20]) begin
          sq_rem_q <= sq_diff[18:0];
          dist_q   <= {dist_q[15:0], 1'b1};
        end else begin
          sq_rem_q <= sq_r2[18:0];
          dist_q   <= {dist_q[15:0], 1'b0};
        end
      end
      OP_STEP_MUL: step_q <= prod[31:16];
      OP_STEP_LIM: if ({1'b0, step_q} > dist_q) step_q <= dist_q[15:0];
      // product < dist * 2^16, so the upper half starts below the divisor
      OP_LANE_MUL: begin
        rem_q[cmd_i.lane] <= {1'b0, prod[31:16]};
        quo_q[cmd_i.lane] <= prod[15:0];
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < LANES; i++) begin
          if ({rem_q[i], quo_q[i][15]} >= {1'b0, dist_q}) begin
            rem_q[i] <= 17'({rem_q[i], quo_q[i][15]} - {1'b0, dist_q});
            quo_q[i] <= {quo_q[i][14:0], 1'b1};
          end else begin
            rem_q[i] <= {rem_q[i][15:0], quo_q[i][15]};
            quo_q[i] <= {quo_q[i][14:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_x_q  <= cur_x_q;
      pos_y_q  <= cur_y_q;
      vel_x_oq <= vel_x_q[16:0];
      vel_y_oq <= vel_y_q[16:0];
      arr_oq   <= arrived_q;
    end
  end

  assign stat_o.mode    = mode_q;
  assign stat_o.arrived = arrived_q;
  assign stat_o.near    = (d2_q < SNAP_SQ);

  assign pos_x_o   = pos_x_q;
  assign pos_y_o   = pos_y_q;
  assign vel_x_o   = vel_x_oq;
  assign vel_y_o   = vel_y_oq;
  assign arrived_o = arr_oq;

endmodule

### bench/ptm_checker.sv
`timescale 1ns / 1ps
// Checker for the point-to-target mover: watches config, input and output
// channels, predicts each result beat and compares. Depends on ptm_pkg.
module ptm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic [15:0]        tick_time_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [16:0] vel_x_i,
  input  logic signed [16:0] vel_y_i,
  input  logic               arrived_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import ptm_pkg::*;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic               arr;
  } motion_t;

  motion_t motion_q[$];

  longint unsigned m_speed;
  longint m_xmin, m_ymin, m_w, m_h;
  longint m_cx, m_cy, m_gx, m_gy, m_vx, m_vy;
  bit     m_arr;

  function automatic longint clamp_edge(longint v, longint lo, longint sz);
    longint hi;
    hi = lo + sz;
    if (hi > 32767) hi = 32767;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_dir(longint d, longint unsigned mul,
                                       longint unsigned dv);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag * mul) / dv;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic advance_motion(logic [1:0] md, longint x, longint y,
                                longint unsigned dt);
    longint dx, dy;
    longint unsigned d2, span_len, stp;
    if (md == MODE_TICK) begin
      if (m_arr) begin
        m_vx = 0;
        m_vy = 0;
      end else begin
        dx = m_gx - m_cx;
        dy = m_gy - m_cy;
        d2 = dx * dx + dy * dy;
        if (d2 < 4096) begin
          m_cx = m_gx;
          m_cy = m_gy;
          m_vx = 0;
          m_vy = 0;
          m_arr = 1;
        end else begin
          span_len = int_sqrt(d2);
          stp = (m_speed * dt) >> 16;
          if (stp > span_len) stp = span_len;
          m_cx = clamp_edge(m_cx + scale_dir(dx, stp, span_len), m_xmin, m_w);
          m_cy = clamp_edge(m_cy + scale_dir(dy, stp, span_len), m_ymin, m_h);
          m_vx = scale_dir(dx, m_speed, span_len);
          m_vy = scale_dir(dy, m_speed, span_len);
        end
      end
    end else if (md == MODE_TARGET) begin
      m_gx = clamp_edge(x, m_xmin, m_w);
      m_gy = clamp_edge(y, m_ymin, m_h);
      m_arr = 0;
    end else if (md == MODE_POS) begin
      m_cx = x;
      m_cy = y;
    end
  endtask

  assign pending_o = motion_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t e;
    if (!rst_ni) begin
      m_speed = 960; m_xmin = 256; m_ymin = 256; m_w = 12288; m_h = 9088;
      m_cx = 0; m_cy = 0; m_gx = 0; m_gy = 0; m_vx = 0; m_vy = 0; m_arr = 1;
      motion_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPEED:  m_speed = cfg_data_i;
          CFG_X_MIN:  m_xmin = longint'($signed(cfg_data_i));
          CFG_Y_MIN:  m_ymin = longint'($signed(cfg_data_i));
          CFG_WIDTH:  m_w = cfg_data_i[14:0];
          CFG_HEIGHT: m_h = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (motion_q.size() == 0) begin
          $error("unexpected result beat");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = motion_q.pop_front();
          if (pos_x_i !== e.px || pos_y_i !== e.py || vel_x_i !== e.vx ||
              vel_y_i !== e.vy || arrived_i !== e.arr)
            fail_count_o <= fail_count_o + 1;
          if (pos_x_i !== e.px) $error("pos_x exp %0d got %0d", e.px, pos_x_i);
          if (pos_y_i !== e.py) $error("pos_y exp %0d got %0d", e.py, pos_y_i);
          if (vel_x_i !== e.vx) $error("vel_x exp %0d got %0d", e.vx, vel_x_i);
          if (vel_y_i !== e.vy) $error("vel_y exp %0d got %0d", e.vy, vel_y_i);
          if (arrived_i !== e.arr)
            $error("arrived exp %0d got %0d", e.arr, arrived_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_motion(mode_i, coord_x_i, coord_y_i, tick_time_i);
        e.px = m_cx[15:0];
        e.py = m_cy[15:0];
        e.vx = m_vx[16:0];
        e.vy = m_vy[16:0];
        e.arr = m_arr;
        motion_q.push_back(e);
      end
    end
  end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for point_to_target_mover_core: drives config and input
// beats with random idling; ptm_checker does prediction. Depends on ptm_pkg.
module tb_top;
  import ptm_pkg::*;

  logic               clk_i, rst_ni;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid, in_ready;
  logic [1:0]         mode;
  logic signed [15:0] coord_x, coord_y;
  logic [15:0]        tick_time;
  logic               out_valid, out_ready;
  logic signed [15:0] pos_x, pos_y;
  logic signed [16:0] vel_x, vel_y;
  logic               arrived;
  int                 fail_count, pending;
  int                 idle_pct, stall_pct;  // percent idle for sender, receiver
  int                 quiet_cycles;

  // Watchdog: generous vs. a moving tick plus long stall runs.
  localparam int QUIET_LIMIT = 20000;

  point_to_target_mover_core u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .tick_time_i(tick_time),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .vel_x_o(vel_x), .vel_y_o(vel_y),
    .arrived_o(arrived)
  );

  ptm_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .tick_time_i(tick_time),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .vel_x_i(vel_x), .vel_y_i(vel_y),
    .arrived_i(arrived),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog: cycles with no beat accepted on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one config write while idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // one input beat; valid held until accepted, may stay high into the next
  task automatic send_beat(logic [1:0] md, logic [15:0] x, logic [15:0] y,
                           logic [15:0] dt);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    mode      <= md;
    coord_x   <= x;
    coord_y   <= y;
    tick_time <= dt;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);  // tail past the longest tick
  endtask

  task automatic set_box(logic [15:0] sp, logic [15:0] xm, logic [15:0] ym,
                         logic [15:0] w, logic [15:0] h);
    write_reg(CFG_SPEED, sp);
    write_reg(CFG_X_MIN, xm);
    write_reg(CFG_Y_MIN, ym);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // mostly well-formed journeys: target then a run of ticks, some noise
  task automatic random_run(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 12)
        send_beat(MODE_TARGET, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 18)
        send_beat(MODE_POS, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 22)
        send_beat(MODE_NOP, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 26)
        send_beat(MODE_TICK, 16'($urandom), 16'($urandom), 16'hffff);
      else
        send_beat(MODE_TICK, 16'($urandom), 16'($urandom),
                  16'($urandom_range(8000)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; mode = MODE_TICK; coord_x = '0; coord_y = '0;
    tick_time = '0; out_ready = 1'b1;
    idle_pct = 0; stall_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defaults, arrived tick, set target/pos, snap, extremes
    send_beat(MODE_TICK, 16'h0000, 16'h0000, 16'h1234);
    send_beat(MODE_TARGET, 16'sd2000, 16'sd1000, 16'h0000);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    send_beat(MODE_TICK, '0, '0, 16'h1000);
    send_beat(MODE_POS, 16'sd1990, 16'sd1010, '0);
    send_beat(MODE_TICK, '0, '0, 16'h0010);          // inside snap radius
    send_beat(MODE_TICK, '0, '0, 16'h0010);          // already there
    send_beat(MODE_TARGET, 16'h7fff, 16'h8000, '0);  // clamped target
    send_beat(MODE_POS, 16'h8000, 16'h7fff, '0);     // unclamped position
    send_beat(MODE_TICK, 16'hffff, 16'hffff, 16'h0000);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    send_beat(MODE_NOP, 16'hffff, 16'hffff, 16'hffff);
    send_beat(MODE_TICK, '0, '0, 16'h8000);
    drain();
    set_box(16'hffff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_beat(MODE_POS, 16'h8000, 16'h8000, '0);
    send_beat(MODE_TARGET, 16'h7fff, 16'h7fff, '0);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    send_beat(MODE_TICK, '0, '0, 16'h0001);
    send_beat(MODE_POS, 16'h7fff, 16'h7fff, '0);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    drain();
    set_box(16'd0, 16'h7f00, 16'h7f00, 16'h7fff, 16'd0);
    send_beat(MODE_TARGET, 16'h0000, 16'h0000, '0);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    send_beat(MODE_POS, 16'h0000, 16'h0000, '0);
    send_beat(MODE_TICK, '0, '0, 16'hffff);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    set_box(16'd960, 16'd256, 16'd256, 16'd12288, 16'd9088);
    idle_pct = 0;  stall_pct = 0;  random_run(140);
    drain();  // sender waits for every result
    set_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom));
    idle_pct = 77; stall_pct = 0;  random_run(130);
    drain();
    set_box(16'($urandom_range(4000)), -16'sd2000, -16'sd2000, 16'd4000, 16'd4000);
    idle_pct = 0;  stall_pct = 77; random_run(130);
    drain();
    set_box(16'hffff, 16'd256, 16'd256, 16'd12288, 16'd9088);
    idle_pct = 10; stall_pct = 10; random_run(150);
    drain();

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
